// ===== sv/operand_stack_unit_core_macros.svh =====
// assertion macros for the operand stack unit
// used by operand_stack_unit_core
`ifndef OPERAND_STACK_UNIT_CORE_MACROS_SVH
`define OPERAND_STACK_UNIT_CORE_MACROS_SVH
// implication checked on every clock while out of reset
`define OSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define OSU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/osu_pkg.sv =====
// shared types and constants of the operand stack unit
// no dependencies
package osu_pkg;
    localparam int STACK_DEPTH = 256;
    localparam int PC_BITS = 16;
    localparam int ADDR_BITS = $clog2(STACK_DEPTH);
    localparam int CNT_BITS = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] MODE_PUSH = 4'd0;
    localparam logic [3:0] MODE_POP = 4'd1;
    localparam logic [3:0] MODE_DUP = 4'd2;
    localparam logic [3:0] MODE_SWAP = 4'd3;
    localparam logic [3:0] MODE_REV = 4'd4;
    localparam logic [3:0] MODE_DISC = 4'd5;
    localparam logic [3:0] MODE_ADD = 4'd6;
    localparam logic [3:0] MODE_SUB = 4'd7;
    localparam logic [3:0] MODE_JMP = 4'd8;
    localparam logic [3:0] MODE_ROTR = 4'd9;
    localparam logic [3:0] MODE_ROTL = 4'd10;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER = 2'd2;
    localparam logic [1:0] ST_BADJ = 2'd3;

    typedef struct packed {
        logic [3:0] mode;
        logic signed [31:0] push_value;
        logic [8:0] rotate_count;
        logic [15:0] pc_in;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic [15:0] next_pc;
        logic [1:0] status;
        logic [8:0] depth;
    } t_out_word;

    // datapath commands
    typedef struct packed {
        logic rd_en;
        logic [ADDR_BITS-1:0] rd_addr;
        logic wr_en;
        logic [ADDR_BITS-1:0] wr_addr;
        logic [1:0] wr_sel;     // 0 push value, 1 read data, 2 held a, 3 alu
        logic [31:0] wr_push;   // value for a push write
        logic hold_a;           // capture read data into a
        logic hold_b;           // capture read data into b
        logic alu_sub;
    } t_dp_cmd;

    localparam logic [1:0] WSEL_PUSH = 2'd0;
    localparam logic [1:0] WSEL_RD = 2'd1;
    localparam logic [1:0] WSEL_A = 2'd2;
    localparam logic [1:0] WSEL_ALU = 2'd3;

    typedef struct packed {
        logic [31:0] rd_data;
        logic [31:0] a;
        logic [31:0] b;
    } t_dp_stat;
endpackage

// ===== sv/operand_stack_unit_core.sv =====
// top level of the operand stack unit: config register, sequencer and datapath
// depends on osu_pkg, osu_ctrl, osu_datapath and the assertion macro header
//
// channel   direction  handshake          payload
// input     in         i_valid / o_ready  t_in_word
// output    out        o_valid / i_ready  t_out_word
// config    in         i_cfg_we           i_cfg_data (program length)
//
// the result word is registered when the sequencer finishes: push, discard and
// failed or empty operations need no read, pop and dup read the top, jump, swap, add
// and sub read the top two entries, and reverse and rotation walk the affected entries
// in turn, all through the single stack memory port
// the next word is taken the cycle after the result word has been delivered
// synchronous active-low reset clears depth and the program length
`include "operand_stack_unit_core_macros.svh"
module operand_stack_unit_core (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  osu_pkg::t_in_word i_word,
    output logic o_valid,
    input  logic i_ready,
    output osu_pkg::t_out_word o_word,
    input  logic i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    logic [15:0] r_plen;
    osu_pkg::t_dp_cmd w_cmd;
    osu_pkg::t_dp_stat w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_plen <= '0;
        else if (i_cfg_we) r_plen <= i_cfg_data;
    end

    osu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_word(i_word), .i_plen(r_plen), .o_valid(o_valid), .i_ready(i_ready),
        .o_word(o_word), .o_cmd(w_cmd), .i_stat(w_stat)
    );

    osu_datapath u_dp (.i_clk(i_clk), .i_cmd(w_cmd), .o_stat(w_stat));

    `OSU_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, o_valid, !o_ready)
    `OSU_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_word))
    `OSU_ASSERT_IMP(a_depth_range, i_clk, i_rst_n, o_valid, o_word.depth <= 9'd256)
endmodule

// ===== sv/osu_datapath.sv =====
// stack memory, operand holding registers and adder
// depends on osu_pkg
module osu_datapath (
    input  logic i_clk,
    input  osu_pkg::t_dp_cmd i_cmd,
    output osu_pkg::t_dp_stat o_stat
);
    logic [31:0] r_mem [osu_pkg::STACK_DEPTH];
    logic [31:0] r_rd;
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [31:0] n_wd;

    always_comb begin
        case (i_cmd.wr_sel)
            osu_pkg::WSEL_PUSH: n_wd = i_cmd.wr_push;
            osu_pkg::WSEL_RD:   n_wd = r_rd;
            osu_pkg::WSEL_A:    n_wd = r_a;
            default:            n_wd = i_cmd.alu_sub ? r_a - r_b : r_a + r_b;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) r_mem[i_cmd.wr_addr] <= n_wd;
        if (i_cmd.rd_en) r_rd <= r_mem[i_cmd.rd_addr];
        if (i_cmd.hold_a) r_a <= r_rd;
        if (i_cmd.hold_b) r_b <= r_rd;
    end

    assign o_stat = '{rd_data: r_rd, a: r_a, b: r_b};
endmodule

// ===== sv/osu_ctrl.sv =====
// sequencer for stack operations, depth count and result word
// depends on osu_pkg
module osu_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  osu_pkg::t_in_word i_word,
    input  logic [15:0] i_plen,
    output logic o_valid,
    input  logic i_ready,
    output osu_pkg::t_out_word o_word,
    output osu_pkg::t_dp_cmd o_cmd,
    input  osu_pkg::t_dp_stat i_stat
);
    localparam int AB = osu_pkg::ADDR_BITS;
    localparam int CB = osu_pkg::CNT_BITS;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD1 = 3'd1;   // first read issued
    localparam logic [2:0] S_RD2 = 3'd2;   // second read issued
    localparam logic [2:0] S_WR = 3'd3;    // dup write, first swap write, pop and jump results
    localparam logic [2:0] S_WR2 = 3'd4;
    localparam logic [2:0] S_WALK = 3'd5;  // rotate/reverse loop
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_st, n_st;
    logic [CB-1:0] r_cnt, n_cnt;
    osu_pkg::t_in_word r_in;
    logic r_ov, n_ov;
    osu_pkg::t_out_word r_out, n_out;
    logic [CB-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [1:0] r_ph, n_ph;
    logic [CB-1:0] w_need;
    logic [CB-1:0] w_n;
    logic w_full;

    assign o_ready = (r_st == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_word = r_out;
    assign w_n = r_in.rotate_count[CB-1:0];
    assign w_full = (r_cnt == CB'(osu_pkg::STACK_DEPTH));

    always_comb begin
        case (r_in.mode)
            osu_pkg::MODE_POP, osu_pkg::MODE_DUP, osu_pkg::MODE_DISC: w_need = CB'(1);
            osu_pkg::MODE_SWAP, osu_pkg::MODE_ADD, osu_pkg::MODE_SUB,
            osu_pkg::MODE_JMP: w_need = CB'(2);
            default: w_need = '0;
        endcase
    end

    always_comb begin
        n_st = r_st;
        n_cnt = r_cnt;
        n_ov = r_ov;
        n_out = r_out;
        n_lo = r_lo;
        n_hi = r_hi;
        n_ph = r_ph;
        o_cmd = '0;
        if (r_ov && i_ready) n_ov = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (i_valid && o_ready) n_st = S_RD1;
            end
            S_RD1: begin
                n_out = '{popped_value: '0, next_pc: r_in.pc_in, status: osu_pkg::ST_OK,
                          depth: 9'(r_cnt)};
                n_st = S_DONE;
                if (r_cnt < w_need) begin
                    n_out.status = osu_pkg::ST_UNDER;
                end else begin
                    case (r_in.mode)
                        osu_pkg::MODE_PUSH: begin
                            if (w_full) n_out.status = osu_pkg::ST_OVER;
                            else begin
                                o_cmd.wr_en = 1'b1;
                                o_cmd.wr_addr = r_cnt[AB-1:0];
                                o_cmd.wr_sel = osu_pkg::WSEL_PUSH;
                                o_cmd.wr_push = r_in.push_value;
                                n_cnt = r_cnt + 1'b1;
                            end
                        end
                        osu_pkg::MODE_DISC: n_cnt = r_cnt - 1'b1;
                        osu_pkg::MODE_DUP: begin
                            if (w_full) n_out.status = osu_pkg::ST_OVER;
                            else begin
                                o_cmd.rd_en = 1'b1;
                                o_cmd.rd_addr = AB'(r_cnt - 1'b1);
                                n_st = S_WR;
                            end
                        end
                        osu_pkg::MODE_POP, osu_pkg::MODE_SWAP, osu_pkg::MODE_ADD,
                        osu_pkg::MODE_SUB, osu_pkg::MODE_JMP: begin
                            o_cmd.rd_en = 1'b1;
                            o_cmd.rd_addr = AB'(r_cnt - 1'b1);
                            n_st = (r_in.mode == osu_pkg::MODE_POP) ? S_WR : S_RD2;
                        end
                        osu_pkg::MODE_REV: begin
                            if (r_cnt > CB'(1)) begin
                                n_lo = '0;
                                n_hi = r_cnt - 1'b1;
                                n_ph = '0;
                                n_st = S_WALK;
                            end
                        end
                        osu_pkg::MODE_ROTR, osu_pkg::MODE_ROTL: begin
                            if (r_in.rotate_count <= 9'(r_cnt) && w_n != '0 &&
                                !(r_in.mode == osu_pkg::MODE_ROTL && w_n == CB'(1))) begin
                                n_lo = r_cnt - w_n;
                                n_hi = r_cnt - 1'b1;
                                n_ph = '0;
                                n_st = S_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD2: begin
                // rd holds top
                o_cmd.hold_a = 1'b1;
                o_cmd.hold_b = 1'b1;
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_addr = AB'(r_cnt - 2'd2);
                n_st = S_WR;
            end
            S_WR: begin
                case (r_in.mode)
                    osu_pkg::MODE_POP: begin
                        n_cnt = r_cnt - 1'b1;
                        n_out.popped_value = i_stat.rd_data;
                        n_out.depth = 9'(n_cnt);
                    end
                    osu_pkg::MODE_DUP: begin
                        o_cmd.wr_en = 1'b1;
                        o_cmd.wr_addr = r_cnt[AB-1:0];
                        o_cmd.wr_sel = osu_pkg::WSEL_RD;
                        n_cnt = r_cnt + 1'b1;
                        n_out.depth = 9'(n_cnt);
                    end
                    osu_pkg::MODE_SWAP: begin
                        o_cmd.wr_en = 1'b1;
                        o_cmd.wr_addr = AB'(r_cnt - 1'b1);
                        o_cmd.wr_sel = osu_pkg::WSEL_RD;
                        n_st = S_WR2;
                    end
                    osu_pkg::MODE_ADD, osu_pkg::MODE_SUB: begin
                        o_cmd.hold_a = 1'b1;
                        n_st = S_WR2;
                    end
                    default: begin
                        // jump: rd test, b addr
                        n_cnt = r_cnt - 2'd2;
                        n_out.depth = 9'(n_cnt);
                        if (i_stat.rd_data == '0) begin
                            if (i_stat.b[31] || i_stat.b >= {16'd0, i_plen}) begin
                                n_out.next_pc = i_plen;
                                n_out.status = osu_pkg::ST_BADJ;
                            end else begin
                                n_out.next_pc = i_stat.b[15:0];
                            end
                        end else begin
                            n_out.next_pc = r_in.pc_in + 1'b1;
                        end
                    end
                endcase
                if (n_st == S_WR) n_st = S_DONE;
            end
            S_WR2: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.alu_sub = (r_in.mode == osu_pkg::MODE_SUB);
                if (r_in.mode == osu_pkg::MODE_SWAP) begin
                    // a holds old top, write it below
                    o_cmd.wr_addr = AB'(r_cnt - 2'd2);
                    o_cmd.wr_sel = osu_pkg::WSEL_A;
                    o_cmd.alu_sub = 1'b0;
                end else begin
                    o_cmd.wr_addr = AB'(r_cnt - 2'd2);
                    o_cmd.wr_sel = osu_pkg::WSEL_ALU;
                    n_cnt = r_cnt - 1'b1;
                    n_out.depth = 9'(n_cnt);
                end
                n_st = S_DONE;
            end
            S_WALK: begin
                // phase 0 read lo (hi for rotate right), 1 hold it in a and read hi for reverse, 2 write one entry
                case (r_ph)
                    2'd0: begin
                        o_cmd.rd_en = 1'b1;
                        o_cmd.rd_addr = AB'(r_in.mode == osu_pkg::MODE_ROTR ? r_hi : r_lo);
                        n_ph = 2'd1;
                    end
                    2'd1: begin
                        o_cmd.hold_a = 1'b1;
                        if (r_in.mode == osu_pkg::MODE_REV) begin
                            o_cmd.rd_en = 1'b1;
                            o_cmd.rd_addr = r_hi[AB-1:0];
                            n_ph = 2'd2;
                        end else begin
                            n_ph = 2'd3;
                        end
                    end
                    2'd2: begin
                        o_cmd.wr_en = 1'b1;
                        o_cmd.wr_addr = r_lo[AB-1:0];
                        o_cmd.wr_sel = osu_pkg::WSEL_RD;
                        n_ph = 2'd3;
                        n_st = S_WR2;
                    end
                    default: begin
                        // rotate shift loop: move one entry, or write held a at the end
                        if (r_in.mode == osu_pkg::MODE_REV) begin
                            n_ph = 2'd0;
                        end else if (r_lo == r_hi) begin
                            o_cmd.wr_en = 1'b1;
                            o_cmd.wr_addr = r_lo[AB-1:0];
                            o_cmd.wr_sel = osu_pkg::WSEL_A;
                            n_st = S_DONE;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            o_cmd.rd_addr = AB'(r_in.mode == osu_pkg::MODE_ROTR ?
                                                r_hi - 1'b1 : r_lo + 1'b1);
                            n_ph = 2'd2;
                        end
                    end
                endcase
                if (r_ph == 2'd2 && r_in.mode != osu_pkg::MODE_REV) begin
                    o_cmd.wr_addr = AB'(r_in.mode == osu_pkg::MODE_ROTR ? r_hi : r_lo);
                    n_st = S_WALK;
                    if (r_in.mode == osu_pkg::MODE_ROTR) n_hi = r_hi - 1'b1;
                    else n_lo = r_lo + 1'b1;
                end
            end
            default: begin
                n_out.depth = 9'(r_cnt);
                n_ov = 1'b1;
                n_st = S_IDLE;
            end
        endcase
        // reverse: after writing lo from hi, write hi from held a
        if (r_st == S_WR2 && r_in.mode == osu_pkg::MODE_REV) begin
            o_cmd = '0;
            o_cmd.wr_en = 1'b1;
            o_cmd.wr_addr = r_hi[AB-1:0];
            o_cmd.wr_sel = osu_pkg::WSEL_A;
            n_lo = r_lo + 1'b1;
            n_hi = r_hi - 1'b1;
            n_ph = 2'd0;
            n_st = (r_lo + 1'b1 < r_hi - 1'b1) ? S_WALK : S_DONE;
            n_cnt = r_cnt;
            n_out = r_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
            r_ov <= n_ov;
        end
        if (r_st == S_IDLE && i_valid && o_ready) r_in <= i_word;
        r_out <= n_out;
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_ph <= n_ph;
    end
endmodule

// ===== bench/operand_stack_unit_core_tb.sv =====
// testbench for operand_stack_unit_core: random and directed stack operations
// checked word by word against a behavioral stack model in a scoreboard class
// depends on osu_pkg and the rtl of operand_stack_unit_core
`timescale 1ns / 100ps
module operand_stack_unit_core_tb;

    class stack_scoreboard;
        logic [31:0] mem [osu_pkg::STACK_DEPTH];
        int unsigned cnt;
        logic [15:0] prog_len;
        osu_pkg::t_out_word pending [$];
        int errors;

        function void clear();
            cnt = 0;
            prog_len = '0;
            pending.delete();
            errors = 0;
        endfunction

        function void note_input(osu_pkg::t_in_word w);
            osu_pkg::t_out_word r;
            logic [31:0] a, b, addr, test;
            int unsigned n, base;
            int lo, hi;
            r.popped_value = '0;
            r.next_pc = w.pc_in;
            r.status = osu_pkg::ST_OK;
            n = w.rotate_count;
            case (w.mode)
                osu_pkg::MODE_PUSH: begin
                    if (cnt >= osu_pkg::STACK_DEPTH) r.status = osu_pkg::ST_OVER;
                    else begin mem[cnt] = w.push_value; cnt++; end
                end
                osu_pkg::MODE_POP: begin
                    if (cnt == 0) r.status = osu_pkg::ST_UNDER;
                    else begin cnt--; r.popped_value = mem[cnt]; end
                end
                osu_pkg::MODE_DUP: begin
                    if (cnt == 0) r.status = osu_pkg::ST_UNDER;
                    else if (cnt >= osu_pkg::STACK_DEPTH) r.status = osu_pkg::ST_OVER;
                    else begin mem[cnt] = mem[cnt-1]; cnt++; end
                end
                osu_pkg::MODE_SWAP: begin
                    if (cnt < 2) r.status = osu_pkg::ST_UNDER;
                    else begin
                        a = mem[cnt-1]; mem[cnt-1] = mem[cnt-2]; mem[cnt-2] = a;
                    end
                end
                osu_pkg::MODE_REV: begin
                    lo = 0;
                    hi = int'(cnt) - 1;
                    while (lo < hi) begin
                        a = mem[lo]; mem[lo] = mem[hi]; mem[hi] = a;
                        lo++;
                        hi--;
                    end
                end
                osu_pkg::MODE_DISC: begin
                    if (cnt == 0) r.status = osu_pkg::ST_UNDER;
                    else cnt--;
                end
                osu_pkg::MODE_ADD, osu_pkg::MODE_SUB: begin
                    if (cnt < 2) r.status = osu_pkg::ST_UNDER;
                    else begin
                        b = mem[cnt-1]; a = mem[cnt-2]; cnt--;
                        mem[cnt-1] = (w.mode == osu_pkg::MODE_ADD) ? a + b : a - b;
                    end
                end
                osu_pkg::MODE_JMP: begin
                    if (cnt < 2) r.status = osu_pkg::ST_UNDER;
                    else begin
                        addr = mem[cnt-1]; test = mem[cnt-2]; cnt -= 2;
                        if (test == 0) begin
                            if (addr[31] || addr >= {16'd0, prog_len}) begin
                                r.next_pc = prog_len; r.status = osu_pkg::ST_BADJ;
                            end else r.next_pc = addr[15:0];
                        end else r.next_pc = w.pc_in + 16'd1;
                    end
                end
                osu_pkg::MODE_ROTR: begin
                    if (n >= 1 && n <= cnt) begin
                        base = cnt - n; a = mem[cnt-1];
                        for (int i = int'(cnt) - 1; i > int'(base); i--) mem[i] = mem[i-1];
                        mem[base] = a;
                    end
                end
                osu_pkg::MODE_ROTL: begin
                    if (n >= 2 && n <= cnt) begin
                        base = cnt - n; a = mem[base];
                        for (int i = int'(base); i + 1 < int'(cnt); i++) mem[i] = mem[i+1];
                        mem[cnt-1] = a;
                    end
                end
                default: ;
            endcase
            r.depth = cnt[8:0];
            pending.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check_result(osu_pkg::t_out_word got);
            osu_pkg::t_out_word e;
            if (pending.size() == 0) begin
                report("unexpected word", 32'(got), '0);
                return;
            end
            e = pending.pop_front();
            if (got.popped_value !== e.popped_value)
                report("popped_value", got.popped_value, e.popped_value);
            if (got.next_pc !== e.next_pc) report("next_pc", 32'(got.next_pc), 32'(e.next_pc));
            if (got.status !== e.status) report("status", 32'(got.status), 32'(e.status));
            if (got.depth !== e.depth) report("depth", 32'(got.depth), 32'(e.depth));
        endtask
    endclass

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_ready = 0, i_cfg_we = 0;
    logic o_ready, o_valid;
    osu_pkg::t_in_word i_word = '0;
    osu_pkg::t_out_word o_word;
    logic [15:0] i_cfg_data = '0;
    stack_scoreboard sb;
    int cycles = 0;
    bit quiet = 0;
    bit hold_rx = 0;

    operand_stack_unit_core dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 1500000) begin
            $display("operand_stack_unit_core_tb NOT OK");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_word);
        if (i_rst_n && i_valid && o_ready) sb.note_input(i_word);
    end

    // receiver with random stalls and one long hold-off
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                i_ready <= 1'b0;
                repeat (600) @(negedge i_clk);
                hold_rx = 0;
            end
            if (!quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 13);
                i_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else i_ready <= 1'b1;
        end
    end

    // valid stays up after acceptance until the next word or an idle stretch
    task automatic send(logic [3:0] mode, logic [31:0] val, logic [8:0] n, logic [15:0] pc);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_word <= '{mode, val, n, pc};
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic drain_and_config(logic [15:0] len);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        i_cfg_data <= len;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.prog_len = len;
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return $urandom_range(0, 40);
            2: return 32'h8000_0000 | $urandom_range(0, 3);
            3: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic rand_item();
        logic [3:0] m;
        int unsigned d;
        d = sb.cnt;
        m = 4'($urandom_range(0, 15));
        if (m > osu_pkg::MODE_ROTL && $urandom_range(0, 2) != 0) m = osu_pkg::MODE_PUSH;
        if (d < 4 && $urandom_range(0, 1) == 0) m = osu_pkg::MODE_PUSH;
        if (d > 40 && $urandom_range(0, 1) == 0) m = osu_pkg::MODE_DISC;
        send(m, rand_val(),
             ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(0, d + 1)),
             16'($urandom));
    endtask

    initial begin
        int t;
        sb = new();
        sb.clear();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // directed: underflows, extremes, jumps, rotations, unknown modes
        for (int m = 0; m < 16; m++)
            if (4'(m) != osu_pkg::MODE_PUSH) send(4'(m), '0, '0, 16'hffff);
        drain_and_config(16'd100);
        send(osu_pkg::MODE_PUSH, 32'h8000_0000, '0, '0);
        send(osu_pkg::MODE_PUSH, 32'h7fff_ffff, '0, '0);
        send(osu_pkg::MODE_ADD, '0, '0, '0);
        send(osu_pkg::MODE_DUP, '0, '0, '0);
        send(osu_pkg::MODE_SUB, '0, '0, '0);
        send(osu_pkg::MODE_PUSH, '0, '0, '0);
        send(osu_pkg::MODE_PUSH, 32'd50, '0, '0);
        send(osu_pkg::MODE_JMP, '0, '0, 16'd7);
        send(osu_pkg::MODE_PUSH, '0, '0, '0);
        send(osu_pkg::MODE_PUSH, 32'hffff_ffff, '0, '0);
        send(osu_pkg::MODE_JMP, '0, '0, 16'd7);
        send(osu_pkg::MODE_PUSH, 32'd5, '0, '0);
        send(osu_pkg::MODE_PUSH, 32'd5, '0, '0);
        send(osu_pkg::MODE_JMP, '0, '0, 16'hffff);
        for (int i = 0; i < 5; i++) send(osu_pkg::MODE_PUSH, 32'(i), '0, '0);
        send(osu_pkg::MODE_ROTR, '0, 9'd5, '0);
        send(osu_pkg::MODE_ROTL, '0, 9'd1, '0);
        send(osu_pkg::MODE_ROTL, '0, 9'd3, '0);
        send(osu_pkg::MODE_ROTR, '0, 9'd256, '0);
        send(osu_pkg::MODE_REV, '0, '0, '0);
        send(osu_pkg::MODE_SWAP, '0, '0, '0);
        // fill to overflow, with the receiver held off
        hold_rx = 1;
        for (int i = 0; i < 254; i++) send(osu_pkg::MODE_PUSH, $urandom, '0, '0);
        send(osu_pkg::MODE_DUP, '0, '0, '0);
        send(osu_pkg::MODE_REV, '0, '0, '0);
        send(osu_pkg::MODE_ROTR, '0, 9'd256, '0);
        // random phases over several program lengths
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: drain_and_config(16'd0);
                1: drain_and_config(16'hffff);
                2: drain_and_config(16'd20);
                default: drain_and_config(16'($urandom));
            endcase
            if (ph == 3) quiet = 1;
            for (int i = 0; i < 90; i++) rand_item();
        end
        i_valid <= 1'b0;
        t = 0;
        while (sb.pending.size() != 0 && t < 100000) begin
            @(negedge i_clk);
            t++;
        end
        repeat (50) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("operand_stack_unit_core_tb OK");
        else
            $display("operand_stack_unit_core_tb NOT OK");
        $finish;
    end
endmodule
